// ----- rtl/core/dual_button_debounce_fsm_assert.svh -----
// Assertion macros shared by the debounce block's modules.
`ifndef DUAL_BUTTON_DEBOUNCE_FSM_ASSERT_SVH
`define DUAL_BUTTON_DEBOUNCE_FSM_ASSERT_SVH
`ifndef ASSERT_OFF
`define DBF_ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("assertion failed: label");
`define DBF_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("assertion failed: label");
`else
`define DBF_ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define DBF_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

// ----- rtl/core/dbf_pkg.sv -----
// Types and constants for the dual button debounce block.
package dbf_pkg;

	localparam int COUNT_WIDTH    = 16;
	localparam int DT_WIDTH       = 15;
	localparam int CMP_WIDTH      = (COUNT_WIDTH > DT_WIDTH) ? COUNT_WIDTH : DT_WIDTH;
	localparam logic [DT_WIDTH-1:0] DEBOUNCE_RESET = 15'd50;

	typedef enum logic [2:0] {
		ST_BOTH_UP   = 3'd0,
		ST_TWO_DOWN  = 3'd1,
		ST_ONE_DOWN  = 3'd2,
		ST_BOTH_DOWN = 3'd3,
		ST_BOUNCE    = 3'd4
	} dbf_state_t;

	typedef struct packed {
		logic button1_level;
		logic button2_level;
	} dbf_in_t;

	typedef struct packed {
		logic       press1_pulse;
		logic       press2_pulse;
		logic [2:0] machine_state;
	} dbf_out_t;

endpackage

// ----- rtl/core/dbf_skid.sv -----
// Output register with skid stage for the debounce result channel.
`include "dual_button_debounce_fsm_assert.svh"

module dbf_skid (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  dbf_pkg::dbf_out_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output dbf_pkg::dbf_out_t out_data
);

	logic              main_valid_q;
	logic              skid_valid_q;
	dbf_pkg::dbf_out_t main_q;
	dbf_pkg::dbf_out_t skid_q;
	logic              in_xfer;

	// accept while the skid stage is free
	assign in_ready  = !skid_valid_q;
	assign in_xfer   = in_valid && in_ready;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	// control: refill the output register or park the transfer in the skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!main_valid_q || out_ready) begin
			if (skid_valid_q) begin
				main_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= in_xfer;
			end
		end else if (in_xfer) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload: no reset needed
	always_ff @(posedge clk) begin
		if (!main_valid_q || out_ready) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (in_xfer) begin
				main_q <= in_data;
			end
		end else if (in_xfer) begin
			skid_q <= in_data;
		end
	end

	`DBF_ASSERT_IMPLIES(a_skid_behind_main, clk, arst_n, skid_valid_q, main_valid_q)
	`DBF_ASSERT_NEXT(a_stall_fills_skid, clk, arst_n, in_xfer && main_valid_q && !out_ready, skid_valid_q)
	`DBF_ASSERT_NEXT(a_skid_drains, clk, arst_n, skid_valid_q && out_ready, !skid_valid_q && main_valid_q)

endmodule

// ----- rtl/core/dual_button_debounce_fsm.sv -----
// Top level of the dual button debounce state machine.
// Usage:
//  - in channel (in_valid/in_ready/in_data): one sample tick carrying the raw
//    active-low levels of both buttons per transfer.
//  - out channel (out_valid/out_ready/out_data): exactly one result per tick,
//    with the two press pulses and the state after that tick.
//  - cfg channel (cfg_valid/cfg_ready/cfg_data): writes debounce_time; always
//    ready, to be written only while the block is idle.
// The result is registered in the output buffer. Throughput is one tick per
// cycle while in_ready is high: the state update is a few gates and one counter compare
// in the cycle of the transfer, and the result lands in a two-entry output buffer.
// When the receiver stalls, one more tick is taken into the skid stage, after
// which in_ready drops until the output drains.
// Reset puts the machine in the both-up state with all samples released, the
// window counter cleared and debounce_time at 50; no clearing pass is needed.
`include "dual_button_debounce_fsm_assert.svh"

module dual_button_debounce_fsm (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  dbf_pkg::dbf_in_t                in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output dbf_pkg::dbf_out_t               out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [dbf_pkg::DT_WIDTH-1:0]    cfg_data
);

	dbf_pkg::dbf_state_t                 state_q, state_d;
	logic                                exp1_q, exp1_d, exp2_q, exp2_d;
	logic                                prev1_q, prev2_q;
	logic [dbf_pkg::COUNT_WIDTH-1:0]     cnt_q, cnt_d;
	logic [dbf_pkg::DT_WIDTH-1:0]        dt_q;
	logic                                in_xfer;
	logic                                lvl1, lvl2, edge1, edge2;
	logic                                resolve;
	logic                                p1, p2;
	logic                                b1, b2;
	dbf_pkg::dbf_out_t                   res;

	assign cfg_ready = 1'b1;
	assign in_xfer   = in_valid && in_ready;
	assign b1        = in_data.button1_level;
	assign b2        = in_data.button2_level;

	// hold the debounce time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= dbf_pkg::DEBOUNCE_RESET;
		end else if (cfg_valid) begin
			dt_q <= cfg_data;
		end
	end

	// window expiry: exceeded time or saturated counter
	assign resolve = ((dbf_pkg::CMP_WIDTH)'(cnt_q) > (dbf_pkg::CMP_WIDTH)'(dt_q))
		|| (cnt_q == {dbf_pkg::COUNT_WIDTH{1'b1}});

	// next state, expected levels and pulses
	always_comb begin
		state_d = state_q;
		exp1_d  = exp1_q;
		exp2_d  = exp2_q;
		cnt_d   = cnt_q;
		p1      = 1'b0;
		p2      = 1'b0;
		lvl1    = !state_q[1];
		lvl2    = !state_q[0];
		edge1   = lvl1 ? (prev1_q && !b1) : (!prev1_q && b1);
		edge2   = lvl2 ? (prev2_q && !b2) : (!prev2_q && b2);
		case (state_q)
			dbf_pkg::ST_BOTH_UP, dbf_pkg::ST_TWO_DOWN,
			dbf_pkg::ST_ONE_DOWN, dbf_pkg::ST_BOTH_DOWN: begin
				if (edge1 || edge2) begin
					exp1_d  = !lvl1;
					exp2_d  = !lvl2;
					cnt_d   = '0;
					state_d = dbf_pkg::ST_BOUNCE;
				end else begin
					exp1_d = lvl1;
					exp2_d = lvl2;
				end
			end
			dbf_pkg::ST_BOUNCE: begin
				if (resolve) begin
					// a button that matches takes its expected level, else keeps the old one
					p1      = (b1 == exp1_q) && !exp1_q;
					p2      = (b2 == exp2_q) && !exp2_q;
					cnt_d   = '0;
					state_d = dbf_pkg::dbf_state_t'({1'b0, !b1, !b2});
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			default: begin
				exp1_d  = 1'b1;
				exp2_d  = 1'b1;
				state_d = dbf_pkg::ST_BOTH_UP;
			end
		endcase
	end

	// advance the machine on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dbf_pkg::ST_BOTH_UP;
			exp1_q  <= 1'b1;
			exp2_q  <= 1'b1;
			prev1_q <= 1'b1;
			prev2_q <= 1'b1;
			cnt_q   <= '0;
		end else if (in_xfer) begin
			state_q <= state_d;
			exp1_q  <= exp1_d;
			exp2_q  <= exp2_d;
			cnt_q   <= cnt_d;
			// sample edges only in stable states
			if (state_q inside {dbf_pkg::ST_BOTH_UP, dbf_pkg::ST_TWO_DOWN,
					dbf_pkg::ST_ONE_DOWN, dbf_pkg::ST_BOTH_DOWN}) begin
				prev1_q <= b1;
				prev2_q <= b2;
			end
		end
	end

	assign res.press1_pulse  = p1;
	assign res.press2_pulse  = p2;
	assign res.machine_state = state_d;

	dbf_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (res),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	`DBF_ASSERT_IMPLIES(a_cnt_only_bouncing, clk, arst_n, state_q != dbf_pkg::ST_BOUNCE, cnt_q == '0)
	`DBF_ASSERT_NEXT(a_cnt_advances, clk, arst_n, in_xfer && state_q == dbf_pkg::ST_BOUNCE && !resolve, cnt_q == $past(cnt_q) + 1'b1)
	`DBF_ASSERT_IMPLIES(a_pulse_on_resolve, clk, arst_n, p1 || p2, state_q == dbf_pkg::ST_BOUNCE && resolve)

endmodule
